>>> src/brainfuck_step_engine_defines.svh
// Assertion macros for the step engine. Synthesis builds define SYNTH.
`ifndef BRAINFUCK_STEP_ENGINE_DEFINES_SVH
`define BRAINFUCK_STEP_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define BSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bse: same-cycle check failed");
`define BSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bse: next-cycle check failed");
`else
`define BSE_ASSERT_SAME(label, clk, rst, ante, cons)
`define BSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/bse_pkg.sv
package bse_pkg;

   localparam int unsigned ADDR_W = 15;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned REQ_W  = 32;
   localparam int unsigned RSP_W  = 32;

   localparam logic FUNC_LOAD = 1'b0;

   localparam logic [BYTE_W-1:0] CMD_END   = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C;
   localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] EOF_BYTE  = 8'hFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_EXEC,
      ST_SCAN_FWD,
      ST_SCAN_BACK,
      ST_HOLD
   } bse_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] program_counter;
      logic              bracket_error;
      logic              halted;
      logic              input_taken;
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
   } bse_result_type;

endpackage

>>> src/bse_ram.sv
module bse_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/brainfuck_step_engine.sv
// Load word: an address beyond the store has PROGRAM_DEPTH taken off it, once per pass
// through the load state, until it falls inside, and the byte is then written. Step word:
// a bracket jump scans the program one byte at a time through the single program store read
// port. A new word is taken while the previous result waits in the output register. After
// reset the tape is swept to zero, one cell a cycle, with req_tready low.
`include "brainfuck_step_engine_defines.svh"

module brainfuck_step_engine
   import bse_pkg::*;
#(
   parameter int unsigned TAPE_DEPTH    = 32768,
   parameter int unsigned PROGRAM_DEPTH = 32768
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // load_address, load_byte, in_byte, in_present
   input  logic [REQ_W-1:0] req_tdata,
   // func
   input  logic [0:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // out_valid, out_byte, input_taken, halted, bracket_error, program_counter, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int unsigned PAW     = $clog2(PROGRAM_DEPTH);
   localparam int unsigned TAW     = $clog2(TAPE_DEPTH);
   localparam int unsigned PT_W    = (PAW > TAW) ? PAW : TAW;
   localparam int unsigned SUM_W   = (PT_W > BYTE_W) ? PT_W : BYTE_W;
   localparam int unsigned LDA_C_W = ((PAW > ADDR_W) ? PAW : ADDR_W) + 1;
   localparam int unsigned NEST_W  = PAW + 1;
   localparam logic [PAW-1:0] PC_LAST   = PAW'(PROGRAM_DEPTH - 1);
   localparam logic [TAW-1:0] CELL_LAST = TAW'(TAPE_DEPTH - 1);

   bse_state_type     state_ff, state_in;
   logic [PAW-1:0]    pc_ff, pc_in;
   logic [TAW-1:0]    cell_ff, cell_in;
   logic              halt_ff, halt_in;
   logic              err_ff, err_in;
   logic [PAW-1:0]    scan_ff, scan_in;
   logic [NEST_W-1:0] nest_ff, nest_in;
   logic [ADDR_W-1:0] lda_ff, lda_in;
   logic [BYTE_W-1:0] ldb_ff, ldb_in;
   logic [BYTE_W-1:0] inb_ff, inb_in;
   logic              inp_ff, inp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bse_result_type    rsp_ff, rsp_in;
   bse_result_type    hold_ff, hold_in;

   logic              prog_we, prog_re;
   logic [PAW-1:0]    prog_waddr, prog_raddr;
   logic [BYTE_W-1:0] prog_rdata;
   logic              tape_we, tape_re;
   logic [BYTE_W-1:0] tape_wdata, tape_rdata;

   logic [SUM_W-1:0]  add_a, add_sum;
   logic              add_down;
   logic [PAW-1:0]    nxt_base, nxt_pc;
   logic              fin, fin_emit, fin_taken, out_free;
   logic [BYTE_W-1:0] fin_byte;
   bse_result_type    res;

   bse_ram #(.WIDTH(BYTE_W), .DEPTH(PROGRAM_DEPTH)) u_prog (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (prog_waddr),
      .wr_data (ldb_ff),
      .rd_en   (prog_re),
      .rd_addr (prog_raddr),
      .rd_data (prog_rdata)
   );

   bse_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (cell_ff),
      .wr_data (tape_wdata),
      .rd_en   (tape_re),
      .rd_addr (cell_ff),
      .rd_data (tape_rdata)
   );

   // The one shared adder steps the scan address, the cell pointer and the cell value.
   assign add_sum  = add_a + (add_down ? {SUM_W{1'b1}} : SUM_W'(1));
   assign nxt_base = (state_ff == ST_EXEC) ? pc_ff : scan_ff;
   assign nxt_pc   = (nxt_base == PC_LAST) ? '0 : nxt_base + PAW'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cell_in      = cell_ff;
      halt_in      = halt_ff;
      err_in       = err_ff;
      scan_in      = scan_ff;
      nest_in      = nest_ff;
      lda_in       = lda_ff;
      ldb_in       = ldb_ff;
      inb_in       = inb_ff;
      inp_in       = inp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      prog_we      = 1'b0;
      prog_re      = 1'b0;
      prog_waddr   = PAW'(lda_ff);
      prog_raddr   = pc_ff;
      tape_we      = 1'b0;
      tape_re      = 1'b0;
      tape_wdata   = '0;
      add_a        = SUM_W'(scan_ff);
      add_down     = 1'b0;
      fin          = 1'b0;
      fin_emit     = 1'b0;
      fin_taken    = 1'b0;
      fin_byte     = '0;

      case (state_ff)
         ST_CLEAR: begin
            tape_we = 1'b1;
            add_a   = SUM_W'(cell_ff);
            if (cell_ff == CELL_LAST) begin
               cell_in  = '0;
               state_in = ST_IDLE;
            end else begin
               cell_in = TAW'(add_sum);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               lda_in = req_tdata[ADDR_W-1:0];
               ldb_in = req_tdata[ADDR_W+BYTE_W-1:ADDR_W];
               inb_in = req_tdata[ADDR_W+2*BYTE_W-1:ADDR_W+BYTE_W];
               inp_in = req_tdata[ADDR_W+2*BYTE_W];
               if (req_tuser[0] == FUNC_LOAD) begin
                  state_in = ST_LOAD;
               end else begin
                  prog_re  = 1'b1;
                  tape_re  = 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_LOAD: begin
            if (LDA_C_W'(lda_ff) >= LDA_C_W'(PROGRAM_DEPTH)) begin
               lda_in = lda_ff - ADDR_W'(PROGRAM_DEPTH);
            end else begin
               prog_we = 1'b1;
               fin     = 1'b1;
            end
         end
         ST_EXEC: begin
            fin = 1'b1;
            if (!halt_ff && !err_ff) begin
               pc_in = nxt_pc;
               case (prog_rdata)
                  CMD_END: begin
                     halt_in = 1'b1;
                     pc_in   = pc_ff;
                  end
                  CMD_RIGHT: begin
                     add_a   = SUM_W'(cell_ff);
                     cell_in = (cell_ff == CELL_LAST) ? '0 : TAW'(add_sum);
                  end
                  CMD_LEFT: begin
                     add_a    = SUM_W'(cell_ff);
                     add_down = 1'b1;
                     cell_in  = (cell_ff == '0) ? CELL_LAST : TAW'(add_sum);
                  end
                  CMD_INC, CMD_DEC: begin
                     add_a      = SUM_W'(tape_rdata);
                     add_down   = (prog_rdata == CMD_DEC);
                     tape_we    = 1'b1;
                     tape_wdata = add_sum[BYTE_W-1:0];
                  end
                  CMD_OUT: begin
                     fin_emit = 1'b1;
                     fin_byte = tape_rdata;
                  end
                  CMD_IN: begin
                     tape_we    = 1'b1;
                     tape_wdata = inp_ff ? inb_ff : EOF_BYTE;
                     fin_taken  = inp_ff;
                  end
                  CMD_OPEN: begin
                     if (tape_rdata == '0) begin
                        add_a = SUM_W'(pc_ff);
                        pc_in = pc_ff;
                        if (pc_ff == PC_LAST) begin
                           err_in = 1'b1;
                        end else begin
                           fin        = 1'b0;
                           scan_in    = PAW'(add_sum);
                           prog_re    = 1'b1;
                           prog_raddr = PAW'(add_sum);
                           nest_in    = NEST_W'(1);
                           state_in   = ST_SCAN_FWD;
                        end
                     end
                  end
                  CMD_CLOSE: begin
                     if (tape_rdata != '0) begin
                        add_a    = SUM_W'(pc_ff);
                        add_down = 1'b1;
                        pc_in    = pc_ff;
                        if (pc_ff == '0) begin
                           err_in = 1'b1;
                        end else begin
                           fin        = 1'b0;
                           scan_in    = PAW'(add_sum);
                           prog_re    = 1'b1;
                           prog_raddr = PAW'(add_sum);
                           nest_in    = NEST_W'(1);
                           state_in   = ST_SCAN_BACK;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_FWD: begin
            if (prog_rdata == CMD_END) begin
               err_in = 1'b1;
               fin    = 1'b1;
            end else if (prog_rdata == CMD_CLOSE && nest_ff == NEST_W'(1)) begin
               pc_in = nxt_pc;
               fin   = 1'b1;
            end else begin
               if (prog_rdata == CMD_OPEN) begin
                  nest_in = nest_ff + NEST_W'(1);
               end else if (prog_rdata == CMD_CLOSE) begin
                  nest_in = nest_ff - NEST_W'(1);
               end
               if (scan_ff == PC_LAST) begin
                  err_in = 1'b1;
                  fin    = 1'b1;
               end else begin
                  scan_in    = PAW'(add_sum);
                  prog_re    = 1'b1;
                  prog_raddr = PAW'(add_sum);
               end
            end
         end
         ST_SCAN_BACK: begin
            add_down = 1'b1;
            if (prog_rdata == CMD_OPEN && nest_ff == NEST_W'(1)) begin
               pc_in = nxt_pc;
               fin   = 1'b1;
            end else begin
               if (prog_rdata == CMD_CLOSE) begin
                  nest_in = nest_ff + NEST_W'(1);
               end else if (prog_rdata == CMD_OPEN) begin
                  nest_in = nest_ff - NEST_W'(1);
               end
               if (scan_ff == '0) begin
                  err_in = 1'b1;
                  fin    = 1'b1;
               end else begin
                  scan_in    = PAW'(add_sum);
                  prog_re    = 1'b1;
                  prog_raddr = PAW'(add_sum);
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res.program_counter = ADDR_W'(pc_in);
      res.bracket_error   = err_in;
      res.halted          = halt_in;
      res.input_taken     = fin_taken;
      res.out_byte        = fin_byte;
      res.out_valid       = fin_emit;

      if (fin) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pc_ff        <= '0;
         cell_ff      <= '0;
         halt_ff      <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cell_ff      <= cell_in;
         halt_ff      <= halt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      nest_ff <= nest_in;
      lda_ff  <= lda_in;
      ldb_ff  <= ldb_in;
      inb_ff  <= inb_in;
      inp_ff  <= inp_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_ff);

   `BSE_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff)
   `BSE_ASSERT_NEXT(a_error_sticky, clock, reset, err_ff, err_ff)
   `BSE_ASSERT_SAME(a_tape_write_state, clock, reset, tape_we, state_ff == ST_EXEC || state_ff == ST_CLEAR)
   `BSE_ASSERT_NEXT(a_pc_only_in_step, clock, reset, state_ff == ST_LOAD || state_ff == ST_IDLE, $stable(pc_ff))

endmodule
